/* hdl/bust_pkg.sv */
// shared constants, operation codes and control structs for the unique set table
`timescale 1ns / 1ps
package bust_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_IN_W = 32;

  localparam logic [FUNC_W-1:0] OP_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [FUNC_W-1:0] OP_CONTAINS = 2'd2;
  localparam logic [FUNC_W-1:0] OP_CLEAR    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic start;       // request accepted, latch op and key
    logic scan;        // step the lookup
    logic fetch_last;  // read the last stored entry
    logic wr_append;   // store key at the end
    logic wr_move;     // move last entry into the freed slot
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic set_ok;
    logic ok_val;
    logic load_out;    // fill the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              hit;
    logic              scan_done;
    logic              full;
    logic              out_free;
  } sts_t;

endpackage

/* hdl/bust_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bust_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/bust_ctrl.sv */
// controller state machine for the unique set table
`timescale 1ns / 1ps
module bust_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  bust_pkg::sts_t sts_i,
  output bust_pkg::cmd_t cmd_o
);
  import bust_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_MOVE   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.op == OP_CLEAR) begin
          cmd_o.cnt_clr = 1'b1;
          cmd_o.set_ok  = 1'b1;
          cmd_o.ok_val  = 1'b1;
          state_d       = S_RESULT;
        end else if (sts_i.hit) begin
          cmd_o.set_ok = 1'b1;
          state_d      = S_RESULT;
          case (sts_i.op)
            OP_REMOVE: begin
              cmd_o.fetch_last = 1'b1;
              cmd_o.ok_val     = 1'b1;
              state_d          = S_MOVE;
            end
            OP_CONTAINS: cmd_o.ok_val = 1'b1;
            default:     cmd_o.ok_val = 1'b0;
          endcase
        end else if (sts_i.scan_done) begin
          cmd_o.set_ok = 1'b1;
          state_d      = S_RESULT;
          if (sts_i.op == OP_ADD && !sts_i.full) begin
            cmd_o.wr_append = 1'b1;
            cmd_o.cnt_inc   = 1'b1;
            cmd_o.ok_val    = 1'b1;
          end
        end
      end
      S_MOVE: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.cnt_dec = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hdl/bust_dp.sv */
// datapath: key store, fill count, lookup pointer and result register
`timescale 1ns / 1ps
module bust_dp #(
  parameter int unsigned DEPTH     = bust_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = bust_pkg::KEY_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  bust_pkg::cmd_t                          cmd_i,
  output bust_pkg::sts_t                          sts_o,
  input  logic [bust_pkg::KEY_IN_W-1:0]           key_i,
  input  logic [bust_pkg::FUNC_W-1:0]             func_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    out_ok_o,
  output logic [$clog2(DEPTH+1)-1:0]              out_count_o,
  output logic                                    out_empty_o
);
  import bust_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [KEY_WIDTH-1:0] key_q;
  logic [FUNC_W-1:0]    op_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     issue_q, issue_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pend_idx_q;
  logic [AW-1:0]        slot_q;
  logic                 ok_q;
  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic                 out_empty_q;

  logic [63:0]          key_ext;
  logic                 issue_rd;
  logic [CNT_W-1:0]     last_idx;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 match;

  // key taken modulo 2^KEY_WIDTH
  assign key_ext = 64'(key_i);

  assign issue_rd = cmd_i.scan && (issue_q < cnt_q);
  assign last_idx = cnt_q - CNT_W'(1);
  assign rd_en    = issue_rd || cmd_i.fetch_last;
  assign rd_addr  = cmd_i.fetch_last ? last_idx[AW-1:0] : issue_q[AW-1:0];
  assign wr_en    = cmd_i.wr_append || cmd_i.wr_move;
  assign wr_addr  = cmd_i.wr_move ? slot_q : cnt_q[AW-1:0];
  assign wr_data  = cmd_i.wr_move ? rd_data : key_q;
  assign match    = pend_q && (rd_data == key_q);

  bust_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    issue_d = issue_q;
    pend_d  = 1'b0;
    if (cmd_i.start) begin
      issue_d = '0;
    end else if (issue_rd) begin
      issue_d = issue_q + CNT_W'(1);
      pend_d  = 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_ext[KEY_WIDTH-1:0];
      op_q  <= func_i;
    end
    if (issue_rd) begin
      pend_idx_q <= issue_q[AW-1:0];
    end
    if (match) begin
      slot_q <= pend_idx_q;
    end
    if (cmd_i.set_ok) begin
      ok_q <= cmd_i.ok_val;
    end
    if (cmd_i.load_out) begin
      out_ok_q    <= ok_q;
      out_cnt_q   <= cnt_q;
      out_empty_q <= (cnt_q == '0);
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.hit       = match;
  assign sts_o.scan_done = !pend_q && (issue_q >= cnt_q);
  assign sts_o.full      = (cnt_q == CNT_W'(DEPTH));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_count_o = out_cnt_q;
  assign out_empty_o = out_empty_q;

endmodule

/* hdl/bounded_unique_set_table.sv */
// top level of the bounded table of unique keys
//
// channel | dir | tdata (low bit up)                      | tuser
// s_axis  | in  | key[31:0]                               | func[1:0]
// m_axis  | out | ok, count[CNT_W-1:0], is_empty, zero pad | none
//
// a lookup walks the stored keys one per cycle through the single read port of the
// key memory, each registered read word compared with the key; a miss walks all
// stored keys, a hit stops the walk early and a remove hit adds a move step; a clear
// goes straight to the result
// the next request is taken in the cycle after the result is loaded
// reset clears the fill count and the result valid flag; stored keys are kept
// stale and only entries below the count are ever read, so no clearing pass
// one request is in flight at a time; the next one is accepted as soon as the
// result sits in the output register, even while that result is stalled
`timescale 1ns / 1ps
module bounded_unique_set_table #(
  parameter int unsigned DEPTH     = bust_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = bust_pkg::KEY_WIDTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // request side
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [bust_pkg::KEY_IN_W-1:0]               s_axis_tdata,  // key
  input  logic [bust_pkg::FUNC_W-1:0]                 s_axis_tuser,  // func
  // result side
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // ok, count, is_empty, zero pad to whole bytes
  output logic [(($clog2(DEPTH+1) + 2 + 7) / 8) * 8-1:0] m_axis_tdata
);
  import bust_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W  = CNT_W + 2;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  cmd_t             cmd;
  sts_t             sts;
  logic             res_ok;
  logic [CNT_W-1:0] res_count;
  logic             res_empty;

  // sequencing of lookup, append, move and result hand-off
  bust_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // key memory, fill count and result register
  bust_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .key_i       (s_axis_tdata),
    .func_i      (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (res_ok),
    .out_count_o (res_count),
    .out_empty_o (res_empty)
  );

  // pack the result, lowest field first
  assign m_axis_tdata = OUT_TW'({res_empty, res_count, res_ok});

endmodule

/* hdl/bust_chk.sv */
// port level checks for the unique set table, bound to the top level
`timescale 1ns / 1ps
module bust_chk #(
  parameter int unsigned DEPTH = bust_pkg::DEPTH_DEF
) (
  input logic                                        clk_i,
  input logic                                        rst_ni,
  input logic                                        s_axis_tvalid,
  input logic                                        s_axis_tready,
  input logic                                        m_axis_tvalid,
  input logic                                        m_axis_tready,
  input logic [(($clog2(DEPTH+1) + 2 + 7) / 8) * 8-1:0] m_axis_tdata
);
  import bust_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] res_count;
  logic             res_empty;

  assign res_count = m_axis_tdata[CNT_W:1];
  assign res_empty = m_axis_tdata[CNT_W+1];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // a new result only comes out of a busy table
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without a request in flight");

  // count stays within capacity and agrees with the empty flag
  a_count_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_count <= CNT_W'(DEPTH)) && (res_empty == (res_count == '0)))
    else $error("count out of range or empty flag wrong");

endmodule

bind bounded_unique_set_table bust_chk #(.DEPTH(DEPTH)) u_bust_chk (.*);

/* tb/testbench.sv */
// self-checking testbench for the bounded table of unique keys
`timescale 1ns / 1ps
module testbench;
  import bust_pkg::*;

  localparam int unsigned CNT_W    = $clog2(DEPTH_DEF + 1);
  localparam int unsigned RES_W    = ((CNT_W + 2 + 7) / 8) * 8;
  localparam int unsigned POOL_N   = 80;   // more keys than slots, so the table can fill
  localparam int unsigned RAND_N   = 1600;
  localparam int unsigned TAIL_N   = 150;  // last requests run with no idling

  // one request as queued for the driver
  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [KEY_IN_W-1:0] key;
    bit                  drain;  // hold off until every result is back
    bit                  calm;   // no idling on either side
  } set_req_t;

  typedef struct {
    logic             ok;
    logic [CNT_W-1:0] count;
    logic             is_empty;
  } set_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [KEY_IN_W-1:0] s_axis_tdata  = '0;
  logic [FUNC_W-1:0]   s_axis_tuser  = OP_CONTAINS;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [RES_W-1:0]    m_axis_tdata;

  bounded_unique_set_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // key
    .s_axis_tuser  (s_axis_tuser),   // func
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // ok, count, is_empty, zero pad
  );

  always #5 clk_i = ~clk_i;

  // mirror of the table contents and fill count
  logic [KEY_IN_W-1:0] mirror_keys [DEPTH_DEF];
  int unsigned         mirror_fill = 0;

  set_req_t            pending_requests [$];
  set_result_t         awaited_results [$];
  logic [KEY_IN_W-1:0] key_pool [POOL_N];

  int unsigned req_issued   = 0;
  int unsigned req_accepted = 0;
  int unsigned err_cnt      = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  bit          idle_en      = 1'b1;

  // apply one request to the mirror and return the result it must produce
  function automatic set_result_t keyset_apply(logic [FUNC_W-1:0] func,
                                               logic [KEY_IN_W-1:0] key);
    set_result_t res;
    int          slot;
    slot = -1;
    // lookup only covers the valid entries
    for (int i = 0; i < int'(mirror_fill); i++) begin
      if (slot < 0 && mirror_keys[i] == key) slot = i;
    end
    res.ok = 1'b0;
    case (func)
      OP_ADD: begin
        if (slot < 0 && mirror_fill < DEPTH_DEF) begin
          mirror_keys[mirror_fill] = key;
          mirror_fill++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        // last stored key fills the hole; removing the last one just drops it
        if (slot >= 0) begin
          mirror_fill--;
          mirror_keys[slot] = mirror_keys[mirror_fill];
          res.ok = 1'b1;
        end
      end
      OP_CONTAINS: res.ok = (slot >= 0);
      default: begin
        // clear leaves stale keys behind, they are just no longer valid
        mirror_fill = 0;
        res.ok      = 1'b1;
      end
    endcase
    res.count    = mirror_fill[CNT_W-1:0];
    res.is_empty = (mirror_fill == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic queue_req(logic [FUNC_W-1:0] func, logic [KEY_IN_W-1:0] key,
                           bit drain, bit calm);
    set_req_t r;
    r.func  = func;
    r.key   = key;
    r.drain = drain;
    r.calm  = calm;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  // mostly keys from the pool so lookups hit, sometimes any 32-bit value
  function automatic logic [KEY_IN_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  // driver: presents queued requests on the falling edge
  always @(negedge clk_i) begin
    set_req_t cur;
    if (rst_ni) begin
      if (req_issued != req_accepted) begin
        // current request still waiting for tready
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].drain && awaited_results.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        cur = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur.key;
        s_axis_tuser  <= cur.func;
        idle_en       <= !cur.calm;
        req_issued++;
        // gap starts once this request is taken
        if (!cur.calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 18);
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall > 0 && idle_en) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        recv_stall = 0;
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 18);
      end
    end
  end

  // monitor: predicts on request accept, checks on result accept
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected, actual ok %0b count %0d empty %0b",
                   $time, m_axis_tdata[0], m_axis_tdata[CNT_W:1], m_axis_tdata[CNT_W+1]);
          err_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(m_axis_tdata[0]));
          check_field("count", 32'(want.count), 32'(m_axis_tdata[CNT_W:1]));
          check_field("is_empty", 32'(want.is_empty), 32'(m_axis_tdata[CNT_W+1]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.insert(awaited_results.size(),
                               keyset_apply(s_axis_tuser, s_axis_tdata));
        req_accepted++;
      end
    end
  end

  initial begin
    int unsigned made;
    int unsigned burst_len;
    int unsigned pick;
    int unsigned kind;
    bit          calm;
    logic [FUNC_W-1:0] func;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

    // directed: empty table, duplicates, hole fill, last entry, stale keys
    queue_req(OP_CONTAINS, 32'h0000_0000, 1'b0, 1'b0);
    queue_req(OP_REMOVE,   32'h0000_0000, 1'b0, 1'b0);
    queue_req(OP_CLEAR,    32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(OP_ADD,      32'h0000_0000, 1'b0, 1'b0);
    queue_req(OP_ADD,      32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(OP_ADD,      32'h0000_0000, 1'b0, 1'b0);
    queue_req(OP_CONTAINS, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(OP_CONTAINS, 32'h1234_5678, 1'b0, 1'b0);
    queue_req(OP_REMOVE,   32'h1234_5678, 1'b0, 1'b0);
    queue_req(OP_REMOVE,   32'h0000_0000, 1'b0, 1'b0);
    queue_req(OP_CONTAINS, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(OP_REMOVE,   32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(OP_ADD,      32'hA5A5_A5A5, 1'b0, 1'b0);
    queue_req(OP_ADD,      32'h5A5A_5A5A, 1'b0, 1'b0);
    queue_req(OP_ADD,      32'h0000_FFFF, 1'b0, 1'b0);
    queue_req(OP_REMOVE,   32'h0000_FFFF, 1'b0, 1'b0);
    queue_req(OP_CLEAR,    32'h0000_0000, 1'b0, 1'b0);
    queue_req(OP_CONTAINS, 32'hA5A5_A5A5, 1'b0, 1'b0);
    queue_req(OP_REMOVE,   32'hA5A5_A5A5, 1'b0, 1'b0);
    queue_req(OP_ADD,      32'hA5A5_A5A5, 1'b0, 1'b0);

    // fill to capacity, then push past it; waits for the pipe to drain first
    queue_req(OP_CLEAR, $urandom, 1'b1, 1'b0);
    for (int i = 0; i < DEPTH_DEF; i++) queue_req(OP_ADD, key_pool[i], 1'b0, 1'b0);
    queue_req(OP_ADD,      key_pool[POOL_N-1], 1'b0, 1'b0);
    queue_req(OP_ADD,      key_pool[5], 1'b0, 1'b0);
    queue_req(OP_CONTAINS, key_pool[DEPTH_DEF-1], 1'b0, 1'b0);
    queue_req(OP_REMOVE,   key_pool[0], 1'b0, 1'b0);
    queue_req(OP_CONTAINS, key_pool[DEPTH_DEF-1], 1'b0, 1'b0);
    queue_req(OP_ADD,      key_pool[POOL_N-1], 1'b0, 1'b0);
    made = DEPTH_DEF + 7;

    // random bursts: fill runs, mixed traffic and lookup/remove heavy runs
    while (made < RAND_N) begin
      burst_len = $urandom_range(8, 70);
      kind      = $urandom_range(0, 2);
      calm      = (made + TAIL_N >= RAND_N) || ($urandom_range(0, 4) == 0);
      for (int n = 0; n < int'(burst_len) && made < RAND_N; n++) begin
        pick = $urandom_range(0, 99);
        case (kind)
          0:       func = (pick < 90) ? OP_ADD : (pick < 97) ? OP_CONTAINS : OP_REMOVE;
          1:       func = (pick < 40) ? OP_ADD : (pick < 65) ? OP_REMOVE :
                          (pick < 98) ? OP_CONTAINS : OP_CLEAR;
          default: func = (pick < 45) ? OP_REMOVE : (pick < 95) ? OP_CONTAINS :
                          (pick < 98) ? OP_ADD : OP_CLEAR;
        endcase
        queue_req(func, pick_key(), (n == 0) && ($urandom_range(0, 3) == 0), calm);
        made++;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (pending_requests.size() != 0 || req_issued != req_accepted ||
           awaited_results.size() != 0);
    // catch any stray result after the last expected one
    repeat (100) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* bounded_unique_set_table.f */
hdl/bust_pkg.sv
hdl/bust_ram.sv
hdl/bust_ctrl.sv
hdl/bust_dp.sv
hdl/bounded_unique_set_table.sv
hdl/bust_chk.sv
tb/testbench.sv
